>>> sv/pwlti_pkg.sv
// pwlti_pkg: constants and breakpoint tables of the piecewise linear interpolator
// used by the channel interfaces and by piecewise_linear_table_interpolator_top
`default_nettype none

package pwlti_pkg;

    // payload widths
    localparam int ANGLE_W = 16;
    localparam int VALUE_W = 16;

    // breakpoint table
    localparam int TABLE_POINTS = 52;
    localparam int SEG_IDX_W    = $clog2(TABLE_POINTS);

    // widest segment of the table is 187 lsb of angle, so a span fits in 8 bits
    localparam int SEG_W = 8;

    // |y1 - y0| * (angle - x0), rounding half added
    localparam int MAG_W = VALUE_W + SEG_W;

    // reciprocal of a segment span: floor(2^RECIP_SHIFT / span)
    localparam int RECIP_SHIFT = MAG_W;
    localparam int RECIP_W     = 18;

    // quotient estimate and its product with the span
    localparam int QE_W   = 18;
    localparam int PROD_W = QE_W + SEG_W;

    // abscissae, unsigned Q8.8 degrees
    localparam logic [ANGLE_W-1:0] BP_X [TABLE_POINTS] = '{
        16'd812,  16'd980,  16'd1147, 16'd1298, 16'd1467, 16'd1597, 16'd1746, 16'd1897,
        16'd2084, 16'd2217, 16'd2365, 16'd2534, 16'd2668, 16'd2836, 16'd3005, 16'd3156,
        16'd3269, 16'd3438, 16'd3607, 16'd3717, 16'd3904, 16'd4052, 16'd4183, 16'd4367,
        16'd4536, 16'd4628, 16'd4815, 16'd4966, 16'd5117, 16'd5266, 16'd5435, 16'd5568,
        16'd5755, 16'd5888, 16'd6036, 16'd6170, 16'd6356, 16'd6525, 16'd6653, 16'd6787,
        16'd6953, 16'd7084, 16'd7250, 16'd7419, 16'd7549, 16'd7680, 16'd7846, 16'd8015,
        16'd8146, 16'd8312, 16'd8443, 16'd8591
    };

    // ordinates, unsigned Q0.16 with the 0.85 scale already applied
    localparam logic [VALUE_W-1:0] BP_Y [TABLE_POINTS] = '{
        16'd9297,  16'd9069,  16'd10200, 16'd11782, 16'd11442, 16'd12573, 16'd13587,
        16'd15620, 16'd16973, 16'd20477, 16'd23753, 16'd25898, 16'd28605, 16'd31880,
        16'd36058, 16'd40576, 16'd43060, 16'd45205, 16'd46108, 16'd43851, 16'd39105,
        16'd35607, 16'd33345, 16'd28945, 16'd28493, 16'd28716, 16'd30187, 16'd32109,
        16'd35044, 16'd36849, 16'd39896, 16'd44186, 16'd48252, 16'd51979, 16'd54124,
        16'd55143, 16'd56385, 16'd57176, 16'd56045, 16'd55594, 16'd53110, 16'd51639,
        16'd49272, 16'd47461, 16'd44977, 16'd44642, 16'd43400, 16'd41139, 16'd39222,
        16'd37864, 16'd33914, 16'd33123
    };

endpackage

`default_nettype wire

>>> sv/pwlti_sample_if.sv
// pwlti_sample_if: valid/ready channel carrying one angle per beat
// depends on pwlti_pkg
`default_nettype none

interface pwlti_sample_if;

    logic                         valid;
    logic                         ready;
    logic [pwlti_pkg::ANGLE_W-1:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);

endinterface

`default_nettype wire

>>> sv/pwlti_result_if.sv
// pwlti_result_if: valid/ready channel carrying one interpolated value per beat
// depends on pwlti_pkg
`default_nettype none

interface pwlti_result_if;

    logic                         valid;
    logic                         ready;
    logic [pwlti_pkg::VALUE_W-1:0] value;
    logic                         in_range;

    modport source (output valid, output value, output in_range, input ready);
    modport sink   (input valid, input value, input in_range, output ready);

endinterface

`default_nettype wire

>>> sv/piecewise_linear_table_interpolator_top.sv
// piecewise_linear_table_interpolator_top: 8-stage pipeline that interpolates a
// fixed breakpoint table; depends on pwlti_pkg, pwlti_sample_if, pwlti_result_if
//
//   channel   dir   payload               beat
//   sample    in    angle[15:0] Q8.8      one angle
//   result    out   value[15:0] Q0.16,    one result per angle, in order
//                   in_range
//
// one angle enters per cycle while stage 1 can load; each result passes
// through the eight register stages (compare, segment search, table read,
// multiply, reciprocal multiply, span multiply, correction, output).
// reset clears only the stage valid bits. a stall on result holds every
// full stage; ready ripples back so empty stages keep filling.
`default_nettype none

module piecewise_linear_table_interpolator_top (
    input  wire                   clk,
    input  wire                   rst_n,
    pwlti_sample_if.sink          sample,
    pwlti_result_if.source        result
);

    localparam int STAGES  = 8;
    localparam int INNER_N = pwlti_pkg::TABLE_POINTS - 2;
    localparam int SRCH_N  = 1 << pwlti_pkg::SEG_IDX_W;

    // per-segment span and reciprocal, indexed by the upper breakpoint
    logic [pwlti_pkg::SEG_W-1:0]   seg_span  [1:pwlti_pkg::TABLE_POINTS-1];
    logic [pwlti_pkg::RECIP_W-1:0] seg_recip [1:pwlti_pkg::TABLE_POINTS-1];

    for (genvar g = 1; g < pwlti_pkg::TABLE_POINTS; g++)
    begin : g_seg_rom
        localparam int SPAN  = int'(pwlti_pkg::BP_X[g]) - int'(pwlti_pkg::BP_X[g-1]);
        localparam int RECIP = (1 << pwlti_pkg::RECIP_SHIFT) / SPAN;
        assign seg_span[g]  = pwlti_pkg::SEG_W'(SPAN);
        assign seg_recip[g] = pwlti_pkg::RECIP_W'(RECIP);
    end

    // ---------------------------------------------------------------
    // flow control: stage k loads when it is empty or stage k+1 loads
    // ---------------------------------------------------------------
    logic [STAGES:1] v_reg;
    logic [STAGES:1] v_next;
    logic [STAGES+1:1] en;

    always_comb
    begin
        en[STAGES+1] = result.ready;
        for (int k = STAGES; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next[1] = en[1] ? sample.valid : v_reg[1];
        for (int k = 2; k <= STAGES; k++)
        begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign sample.ready = en[1];

    // ---------------------------------------------------------------
    // stage 1: range check and compare against inner breakpoints
    // ---------------------------------------------------------------
    logic [pwlti_pkg::ANGLE_W-1:0] s1_angle_reg;
    logic                          s1_rng_reg, s1_rng_next;
    logic [INNER_N-1:0]            s1_lt_reg, s1_lt_next;

    always_comb
    begin
        s1_rng_next = (sample.angle >= pwlti_pkg::BP_X[0])
                   && (sample.angle < pwlti_pkg::BP_X[pwlti_pkg::TABLE_POINTS-1]);
        for (int i = 0; i < INNER_N; i++)
        begin
            s1_lt_next[i] = pwlti_pkg::BP_X[i+1] < sample.angle;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_angle_reg <= sample.angle;
            s1_rng_reg   <= s1_rng_next;
            s1_lt_reg    <= s1_lt_next;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: binary search of the thermometer code for the segment
    // ---------------------------------------------------------------
    logic [pwlti_pkg::ANGLE_W-1:0]   s2_angle_reg;
    logic                            s2_rng_reg;
    logic [pwlti_pkg::SEG_IDX_W-1:0] s2_hi_reg, s2_hi_next;
    logic [SRCH_N-1:0]               therm;
    logic [pwlti_pkg::SEG_IDX_W-1:0] pos;
    logic [pwlti_pkg::SEG_IDX_W-1:0] probe;

    always_comb
    begin
        therm = SRCH_N'(s1_lt_reg);
        pos   = '0;
        for (int b = pwlti_pkg::SEG_IDX_W - 1; b >= 0; b--)
        begin
            probe = pos + pwlti_pkg::SEG_IDX_W'((1 << b) - 1);
            if (therm[probe])
            begin
                pos = pos + pwlti_pkg::SEG_IDX_W'(1 << b);
            end
        end
        // first breakpoint not below the angle
        s2_hi_next = pos + pwlti_pkg::SEG_IDX_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_angle_reg <= s1_angle_reg;
            s2_rng_reg   <= s1_rng_reg;
            s2_hi_reg    <= s2_hi_next;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: table read, offset into segment, ordinate step
    // ---------------------------------------------------------------
    logic                            s3_rng_reg;
    logic [pwlti_pkg::SEG_W-1:0]     s3_dx_reg, s3_dx_next;
    logic [pwlti_pkg::VALUE_W-1:0]   s3_dy_reg, s3_dy_next;
    logic                            s3_neg_reg, s3_neg_next;
    logic [pwlti_pkg::VALUE_W-1:0]   s3_y0_reg, s3_y0_next;
    logic [pwlti_pkg::SEG_W-1:0]     s3_span_reg;
    logic [pwlti_pkg::RECIP_W-1:0]   s3_recip_reg;
    logic [pwlti_pkg::SEG_IDX_W-1:0] lo_idx;
    logic [pwlti_pkg::VALUE_W-1:0]   y1;
    logic [pwlti_pkg::ANGLE_W-1:0]   dx_full;

    always_comb
    begin
        lo_idx      = s2_hi_reg - pwlti_pkg::SEG_IDX_W'(1);
        s3_y0_next  = pwlti_pkg::BP_Y[lo_idx];
        y1          = pwlti_pkg::BP_Y[s2_hi_reg];
        // the offset never exceeds the span while in range
        dx_full     = s2_angle_reg - pwlti_pkg::BP_X[lo_idx];
        s3_dx_next  = dx_full[pwlti_pkg::SEG_W-1:0];
        s3_neg_next = y1 < s3_y0_next;
        s3_dy_next  = s3_neg_next ? (s3_y0_next - y1) : (y1 - s3_y0_next);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_rng_reg   <= s2_rng_reg;
            s3_dx_reg    <= s3_dx_next;
            s3_dy_reg    <= s3_dy_next;
            s3_neg_reg   <= s3_neg_next;
            s3_y0_reg    <= s3_y0_next;
            s3_span_reg  <= seg_span[s2_hi_reg];
            s3_recip_reg <= seg_recip[s2_hi_reg];
        end
    end

    // ---------------------------------------------------------------
    // stage 4: numerator magnitude plus half span for round to nearest
    // ---------------------------------------------------------------
    logic                          s4_rng_reg;
    logic [pwlti_pkg::MAG_W-1:0]   s4_num_reg, s4_num_next;
    logic                          s4_neg_reg;
    logic [pwlti_pkg::VALUE_W-1:0] s4_y0_reg;
    logic [pwlti_pkg::SEG_W-1:0]   s4_span_reg;
    logic [pwlti_pkg::RECIP_W-1:0] s4_recip_reg;

    always_comb
    begin
        s4_num_next = (pwlti_pkg::MAG_W'(s3_dy_reg) * pwlti_pkg::MAG_W'(s3_dx_reg))
                    + pwlti_pkg::MAG_W'(s3_span_reg >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_rng_reg   <= s3_rng_reg;
            s4_num_reg   <= s4_num_next;
            s4_neg_reg   <= s3_neg_reg;
            s4_y0_reg    <= s3_y0_reg;
            s4_span_reg  <= s3_span_reg;
            s4_recip_reg <= s3_recip_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 5: quotient estimate by reciprocal, low by at most one
    // ---------------------------------------------------------------
    localparam int RPROD_W = pwlti_pkg::MAG_W + pwlti_pkg::RECIP_W;

    logic                          s5_rng_reg;
    logic [pwlti_pkg::MAG_W-1:0]   s5_num_reg;
    logic [pwlti_pkg::QE_W-1:0]    s5_qe_reg, s5_qe_next;
    logic                          s5_neg_reg;
    logic [pwlti_pkg::VALUE_W-1:0] s5_y0_reg;
    logic [pwlti_pkg::SEG_W-1:0]   s5_span_reg;
    logic [RPROD_W-1:0]            rprod;

    always_comb
    begin
        rprod      = RPROD_W'(s4_num_reg) * RPROD_W'(s4_recip_reg);
        s5_qe_next = rprod[pwlti_pkg::RECIP_SHIFT +: pwlti_pkg::QE_W];
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_rng_reg  <= s4_rng_reg;
            s5_num_reg  <= s4_num_reg;
            s5_qe_reg   <= s5_qe_next;
            s5_neg_reg  <= s4_neg_reg;
            s5_y0_reg   <= s4_y0_reg;
            s5_span_reg <= s4_span_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 6: estimate times span for the remainder check
    // ---------------------------------------------------------------
    logic                          s6_rng_reg;
    logic [pwlti_pkg::MAG_W-1:0]   s6_num_reg;
    logic [pwlti_pkg::QE_W-1:0]    s6_qe_reg;
    logic [pwlti_pkg::PROD_W-1:0]  s6_prod_reg, s6_prod_next;
    logic                          s6_neg_reg;
    logic [pwlti_pkg::VALUE_W-1:0] s6_y0_reg;
    logic [pwlti_pkg::SEG_W-1:0]   s6_span_reg;

    assign s6_prod_next = pwlti_pkg::PROD_W'(s5_qe_reg) * pwlti_pkg::PROD_W'(s5_span_reg);

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s6_rng_reg  <= s5_rng_reg;
            s6_num_reg  <= s5_num_reg;
            s6_qe_reg   <= s5_qe_reg;
            s6_prod_reg <= s6_prod_next;
            s6_neg_reg  <= s5_neg_reg;
            s6_y0_reg   <= s5_y0_reg;
            s6_span_reg <= s5_span_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 7: bump the estimate when the remainder reaches the span
    // ---------------------------------------------------------------
    logic                          s7_rng_reg;
    logic [pwlti_pkg::QE_W-1:0]    s7_q_reg, s7_q_next;
    logic                          s7_neg_reg;
    logic [pwlti_pkg::VALUE_W-1:0] s7_y0_reg;
    logic [pwlti_pkg::PROD_W-1:0]  rem;

    always_comb
    begin
        rem = pwlti_pkg::PROD_W'(s6_num_reg) - s6_prod_reg;
        if (rem >= pwlti_pkg::PROD_W'(s6_span_reg))
        begin
            s7_q_next = s6_qe_reg + pwlti_pkg::QE_W'(1);
        end
        else
        begin
            s7_q_next = s6_qe_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s7_rng_reg <= s6_rng_reg;
            s7_q_reg   <= s7_q_next;
            s7_neg_reg <= s6_neg_reg;
            s7_y0_reg  <= s6_y0_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 8: apply step to lower ordinate, zero when out of range
    // ---------------------------------------------------------------
    logic [pwlti_pkg::VALUE_W-1:0] s8_value_reg, s8_value_next;
    logic                          s8_rng_reg;
    logic [pwlti_pkg::QE_W-1:0]    y_sum;

    always_comb
    begin
        // result stays between the two ordinates, so no saturation is needed
        if (s7_neg_reg)
        begin
            y_sum = pwlti_pkg::QE_W'(s7_y0_reg) - s7_q_reg;
        end
        else
        begin
            y_sum = pwlti_pkg::QE_W'(s7_y0_reg) + s7_q_reg;
        end
        s8_value_next = s7_rng_reg ? y_sum[pwlti_pkg::VALUE_W-1:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            s8_value_reg <= s8_value_next;
            s8_rng_reg   <= s7_rng_reg;
        end
    end

    assign result.valid    = v_reg[STAGES];
    assign result.value    = s8_value_reg;
    assign result.in_range = s8_rng_reg;

endmodule

`default_nettype wire
